[design/tcsem_pkg.sv]
// Shared types and constants of the timed counting semaphore.
`timescale 1ns / 1ps
`default_nettype none
package tcsem_pkg;

	localparam int QUEUE_DEPTH    = 16;
	localparam int THREAD_ID_BITS = 8;
	localparam int TIMER_BITS     = 16;

	localparam int QIDX_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_BITS  = $clog2(QUEUE_DEPTH + 1);
	localparam int COUNT_BITS = 16;
	localparam int CFG_BITS   = 15;
	localparam int SIG_BITS   = 16;
	localparam int WAIT_BITS  = 16;
	localparam int MODE_BITS  = 2;
	localparam int KIND_BITS  = 3;

	localparam logic [MODE_BITS-1:0] MODE_WAIT   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_SIGNAL = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_TICK   = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_GRANTED   = 3'd0,
		KIND_QUEUED    = 3'd1,
		KIND_RELEASED  = 3'd2,
		KIND_TIMEOUT   = 3'd3,
		KIND_SIG_DONE  = 3'd4,
		KIND_TICK_DONE = 3'd5,
		KIND_FULL      = 3'd6
	} kind_t;

	typedef struct packed {
		logic [THREAD_ID_BITS-1:0] id;
		logic [TIMER_BITS-1:0]     timer;
		logic                      timed;
	} entry_t;

	typedef struct packed {
		logic                 shift;
		logic                 load;
		logic [QIDX_BITS-1:0] load_idx;
	} queue_ctrl_t;

endpackage
`default_nettype wire

[design/tcsem_cell.sv]
// One waiter slot of the queue: loads a new entry or takes its neighbor's.
`timescale 1ns / 1ps
`default_nettype none
module tcsem_cell
	import tcsem_pkg::*;
(
	input  wire    clk,
	input  wire    load,
	input  wire    shift,
	input  entry_t load_data,
	input  entry_t next_data,
	output entry_t data
);

	entry_t data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

[design/tcsem_queue.sv]
// Row of waiter cells; head at cell 0, shifts toward the head.
`timescale 1ns / 1ps
`default_nettype none
module tcsem_queue
	import tcsem_pkg::*;
(
	input  wire         clk,
	input  queue_ctrl_t ctrl,
	input  entry_t      load_data,
	output entry_t      head
);

	entry_t cell_data [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t next_data;
		logic   load_here;

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_data = cell_data[i];
		end else begin : g_mid
			assign next_data = cell_data[i + 1];
		end

		assign load_here = ctrl.load && (ctrl.load_idx == QIDX_BITS'(i));

		tcsem_cell u_cell (
			.clk       (clk),
			.load      (load_here),
			.shift     (ctrl.shift),
			.load_data (load_data),
			.next_data (next_data),
			.data      (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule
`default_nettype wire

[design/timed_counting_semaphore.sv]
// Top level: semaphore count, queue control sequencer and result register.
// Wait, negative signal: one result beat the cycle after start; busy stays low.
// Signal n > 0: r = min(n, fill) release beats, one per cycle, then the done beat; n = 0
//   releases the head waiter only while the count is negative. Tick: the queue rotates
//   through the head cell, one waiter per cycle, then the done beat. busy drops as the
//   done beat is set, so the next item may start on that edge. Results cannot be stalled.
//   Reset: count 0, queue empty; a config write loads the count and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module timed_counting_semaphore
	import tcsem_pkg::*;
(
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire         [MODE_BITS-1:0]       mode,
	input  wire         [THREAD_ID_BITS-1:0]  thread_id,
	input  wire         [WAIT_BITS-1:0]       max_wait,
	input  wire  signed [SIG_BITS-1:0]        signal_count,
	output logic                              strobe,
	output logic        [KIND_BITS-1:0]       kind,
	output logic        [THREAD_ID_BITS-1:0]  thread_out,
	output logic signed [COUNT_BITS-1:0]      value,
	output logic                              last,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire         [CFG_BITS-1:0]        cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SIG  = 3'b010,
		ST_TICK = 3'b100
	} state_t;

	localparam logic signed [COUNT_BITS+1:0] SUM_MAX = 18'sd32767;
	localparam logic signed [COUNT_BITS+1:0] SUM_MIN = -18'sd32768;

	function automatic logic signed [COUNT_BITS-1:0] sat_add(
		input logic signed [COUNT_BITS-1:0] a,
		input logic signed [COUNT_BITS:0]   b
	);
		logic signed [COUNT_BITS+1:0] s;
		s = $signed({{2{a[COUNT_BITS-1]}}, a}) + $signed({b[COUNT_BITS], b});
		if (s > SUM_MAX) begin
			return SUM_MAX[COUNT_BITS-1:0];
		end else if (s < SUM_MIN) begin
			return SUM_MIN[COUNT_BITS-1:0];
		end
		return s[COUNT_BITS-1:0];
	endfunction

	state_t                          state_q, state_d;
	logic signed [COUNT_BITS-1:0]    count_q, count_d;
	logic [FILL_BITS-1:0]            fill_q, fill_d;
	logic [CFG_BITS-1:0]             rem_q, rem_d;
	logic [CFG_BITS-1:0]             add_q, add_d;
	logic [FILL_BITS-1:0]            rel_q, rel_d;
	logic [FILL_BITS-1:0]            iter_q, iter_d;
	logic                            zero_q, zero_d;

	logic                            strobe_q, strobe_d;
	kind_t                           kind_q, kind_d;
	logic [THREAD_ID_BITS-1:0]       thr_q, thr_d;
	logic signed [COUNT_BITS-1:0]    val_q, val_d;
	logic                            last_q, last_d;

	queue_ctrl_t                     qctrl;
	entry_t                          load_data;
	entry_t                          head;
	logic signed [COUNT_BITS-1:0]    dec_count;
	logic [TIMER_BITS-1:0]           wait_timer;
	logic [TIMER_BITS-1:0]           head_timer_dec;
	logic                            cfg_we;

	tcsem_queue u_queue (
		.clk       (clk),
		.ctrl      (qctrl),
		.load_data (load_data),
		.head      (head)
	);

	assign cfg_ready      = (state_q == ST_IDLE) && !start;
	assign busy           = (state_q != ST_IDLE);
	assign cfg_we         = cfg_valid && cfg_ready;
	assign dec_count      = sat_add(count_q, -17'sd1);
	assign wait_timer     = TIMER_BITS'(max_wait);
	assign head_timer_dec = (head.timer != '0) ? head.timer - 1'b1 : head.timer;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		fill_d    = fill_q;
		rem_d     = rem_q;
		add_d     = add_q;
		rel_d     = rel_q;
		iter_d    = iter_q;
		zero_d    = zero_q;
		strobe_d  = 1'b0;
		kind_d    = kind_q;
		thr_d     = thr_q;
		val_d     = val_q;
		last_d    = last_q;
		qctrl     = '0;
		load_data = head;

		case (state_q)
			ST_IDLE: begin
				if (cfg_we) begin
					count_d = $signed({1'b0, cfg_data});
					fill_d  = '0;
				end else if (start) begin
					case (mode)
						MODE_WAIT: begin
							strobe_d = 1'b1;
							thr_d    = thread_id;
							val_d    = '0;
							last_d   = 1'b1;
							if (!dec_count[COUNT_BITS-1]) begin
								count_d = dec_count;
								kind_d  = KIND_GRANTED;
							end else if (fill_q == FILL_BITS'(QUEUE_DEPTH)) begin
								kind_d  = KIND_FULL;
							end else begin
								count_d         = dec_count;
								qctrl.load      = 1'b1;
								qctrl.load_idx  = QIDX_BITS'(fill_q);
								load_data.id    = thread_id;
								load_data.timer = wait_timer;
								load_data.timed = (wait_timer != '0);
								fill_d          = fill_q + 1'b1;
								kind_d          = KIND_QUEUED;
							end
						end
						MODE_SIGNAL: begin
							if (signal_count < 0) begin
								strobe_d = 1'b1;
								kind_d   = KIND_SIG_DONE;
								thr_d    = '0;
								val_d    = signal_count;
								last_d   = 1'b1;
							end else begin
								rel_d   = '0;
								state_d = ST_SIG;
								if (signal_count == 0) begin
									zero_d = 1'b1;
									add_d  = CFG_BITS'(1);
									rem_d  = CFG_BITS'(count_q[COUNT_BITS-1]);
								end else begin
									zero_d = 1'b0;
									add_d  = signal_count[CFG_BITS-1:0];
									rem_d  = signal_count[CFG_BITS-1:0];
								end
							end
						end
						MODE_TICK: begin
							iter_d  = fill_q;
							state_d = ST_TICK;
						end
						default: ;
					endcase
				end
			end
			ST_SIG: begin
				strobe_d = 1'b1;
				val_d    = '0;
				if (fill_q != '0 && rem_q != '0) begin
					kind_d      = KIND_RELEASED;
					thr_d       = head.id;
					last_d      = 1'b0;
					qctrl.shift = 1'b1;
					fill_d      = fill_q - 1'b1;
					rem_d       = rem_q - 1'b1;
					rel_d       = rel_q + 1'b1;
				end else begin
					count_d = sat_add(count_q, $signed({2'b00, add_q}));
					kind_d  = KIND_SIG_DONE;
					thr_d   = '0;
					val_d   = zero_q ? '0 : $signed(COUNT_BITS'(rel_q));
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				val_d = '0;
				if (iter_q == '0) begin
					strobe_d = 1'b1;
					kind_d   = KIND_TICK_DONE;
					thr_d    = '0;
					last_d   = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					iter_d      = iter_q - 1'b1;
					qctrl.shift = 1'b1;
					if (head_timer_dec == '0 && head.timed) begin
						strobe_d = 1'b1;
						kind_d   = KIND_TIMEOUT;
						thr_d    = head.id;
						last_d   = 1'b0;
						count_d  = sat_add(count_q, 17'sd1);
						fill_d   = fill_q - 1'b1;
					end else begin
						// survivor goes back in at the tail
						qctrl.load      = 1'b1;
						qctrl.load_idx  = QIDX_BITS'(fill_q - 1'b1);
						load_data.timer = head_timer_dec;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			fill_q   <= '0;
			rem_q    <= '0;
			add_q    <= '0;
			rel_q    <= '0;
			iter_q   <= '0;
			zero_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			fill_q   <= fill_d;
			rem_q    <= rem_d;
			add_q    <= add_d;
			rel_q    <= rel_d;
			iter_q   <= iter_d;
			zero_q   <= zero_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		thr_q  <= thr_d;
		val_q  <= val_d;
		last_q <= last_d;
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign thread_out = thr_q;
	assign value      = val_q;
	assign last       = last_q;

endmodule
`default_nettype wire

[design/tcsem_checker.sv]
// Port-level checks for the timed counting semaphore, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tcsem_checker
	import tcsem_pkg::*;
(
	input wire                              clk,
	input wire                              arst_n,
	input wire                              start,
	input wire                              busy,
	input wire        [MODE_BITS-1:0]       mode,
	input wire        [THREAD_ID_BITS-1:0]  thread_id,
	input wire                              strobe,
	input wire        [KIND_BITS-1:0]       kind,
	input wire        [THREAD_ID_BITS-1:0]  thread_out,
	input wire signed [COUNT_BITS-1:0]      value,
	input wire                              last
);

	a_unused_mode_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_UNUSED |=> !strobe)
		else $error("result beat after an unused mode");

	a_wait_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_WAIT |=> strobe && last && !busy &&
		(kind == KIND_GRANTED || kind == KIND_QUEUED || kind == KIND_FULL) &&
		thread_out == $past(thread_id))
		else $error("wait did not answer with one beat for its thread");

	a_more_beats_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final beat while idle");

	a_done_no_thread: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_SIG_DONE || kind == KIND_TICK_DONE) |->
		thread_out == '0 && last)
		else $error("done beat carries a thread or is not final");

	a_value_only_signal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind != KIND_SIG_DONE |-> value == '0)
		else $error("nonzero value outside a signal done beat");

endmodule

bind timed_counting_semaphore tcsem_checker u_tcsem_checker (.*);
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench of the timed counting semaphore: queued ops, predicted beats.
`timescale 1ns / 1ps
module testbench;
	import tcsem_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct packed {
		logic [MODE_BITS-1:0]      mode;
		logic [THREAD_ID_BITS-1:0] tid;
		logic [WAIT_BITS-1:0]      max_wait;
		logic [SIG_BITS-1:0]       n;
	} sem_op_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]      kind;
		logic [THREAD_ID_BITS-1:0] thread;
		logic [COUNT_BITS-1:0]     value;
		logic                      last;
	} sem_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [MODE_BITS-1:0]       mode = MODE_WAIT;
	logic [THREAD_ID_BITS-1:0]  thread_id = '0;
	logic [WAIT_BITS-1:0]       max_wait = '0;
	logic signed [SIG_BITS-1:0] signal_count = '0;
	logic                       strobe;
	logic [KIND_BITS-1:0]       kind;
	logic [THREAD_ID_BITS-1:0]  thread_out;
	logic signed [COUNT_BITS-1:0] value;
	logic                       last;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_BITS-1:0]        cfg_data = '0;

	// semaphore image
	int                        count_now = 0;
	logic [THREAD_ID_BITS-1:0] line_id [QUEUE_DEPTH];
	logic [TIMER_BITS-1:0]     line_timer [QUEUE_DEPTH];
	logic                      line_timed [QUEUE_DEPTH];
	int                        line_len = 0;

	sem_op_t     op_queue[$];
	sem_result_t due_results[$];
	sem_op_t     next_op;
	sem_result_t seen;
	sem_result_t want;
	int          mismatches = 0;
	int          cycles = 0;
	int          gap_left = 0;
	logic        taken = 1'b0;
	logic        steady = 1'b0;

	timed_counting_semaphore u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.thread_id    (thread_id),
		.max_wait     (max_wait),
		.signal_count (signal_count),
		.strobe       (strobe),
		.kind         (kind),
		.thread_out   (thread_out),
		.value        (value),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int clamp_count(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic void post(kind_t k, logic [THREAD_ID_BITS-1:0] t, int v);
		sem_result_t r;
		r.kind = k;
		r.thread = t;
		r.value = COUNT_BITS'(v);
		r.last = 1'b0;
		due_results.push_back(r);
	endfunction

	function automatic void drop_waiter(int pos);
		for (int i = pos; i + 1 < line_len; i++) begin
			line_id[i] = line_id[i + 1];
			line_timer[i] = line_timer[i + 1];
			line_timed[i] = line_timed[i + 1];
		end
		line_len--;
	endfunction

	function automatic void semaphore_step(sem_op_t op);
		int          first;
		int          n;
		int          freed;
		int          i;
		sem_result_t r;
		first = due_results.size();
		n = $signed(op.n);
		case (op.mode)
			MODE_WAIT: begin
				if (clamp_count(count_now - 1) >= 0) begin
					count_now = clamp_count(count_now - 1);
					post(KIND_GRANTED, op.tid, 0);
				end else if (line_len >= QUEUE_DEPTH) begin
					post(KIND_FULL, op.tid, 0);
				end else begin
					count_now = clamp_count(count_now - 1);
					line_id[line_len] = op.tid;
					line_timer[line_len] = op.max_wait;
					line_timed[line_len] = (op.max_wait != 0);
					line_len++;
					post(KIND_QUEUED, op.tid, 0);
				end
			end
			MODE_SIGNAL: begin
				if (n < 0) begin
					post(KIND_SIG_DONE, '0, n);
				end else if (n == 0) begin
					if (count_now < 0 && line_len > 0) begin
						post(KIND_RELEASED, line_id[0], 0);
						drop_waiter(0);
					end
					count_now = clamp_count(count_now + 1);
					post(KIND_SIG_DONE, '0, 0);
				end else begin
					freed = 0;
					while (line_len > 0 && freed < n) begin
						post(KIND_RELEASED, line_id[0], 0);
						drop_waiter(0);
						freed++;
					end
					count_now = clamp_count(count_now + n);
					post(KIND_SIG_DONE, '0, freed);
				end
			end
			MODE_TICK: begin
				i = 0;
				while (i < line_len) begin
					if (line_timer[i] != 0)
						line_timer[i] = line_timer[i] - 1'b1;
					if (line_timer[i] == 0 && line_timed[i]) begin
						post(KIND_TIMEOUT, line_id[i], 0);
						count_now = clamp_count(count_now + 1);
						drop_waiter(i);
					end else begin
						i++;
					end
				end
				post(KIND_TICK_DONE, '0, 0);
			end
			default: ;
		endcase
		if (due_results.size() > first) begin
			r = due_results[due_results.size() - 1];
			r.last = 1'b1;
			due_results[due_results.size() - 1] = r;
		end
	endfunction

	task automatic add_op(logic [MODE_BITS-1:0] m, logic [THREAD_ID_BITS-1:0] t,
		logic [WAIT_BITS-1:0] w, logic [SIG_BITS-1:0] n);
		sem_op_t op;
		op = '{m, t, w, n};
		op_queue.push_back(op);
	endtask

	task automatic add_random_ops(int count);
		sem_op_t op;
		int      done;
		int      r;
		done = 0;
		while (done < count) begin
			op.tid = THREAD_ID_BITS'($urandom);
			op.max_wait = WAIT_BITS'($urandom);
			op.n = SIG_BITS'($urandom);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				op.mode = MODE_WAIT;
				r = $urandom_range(0, 99);
				if (r < 40)
					op.max_wait = '0;
				else if (r < 85)
					op.max_wait = WAIT_BITS'($urandom_range(1, 6));
			end else if (r < 70) begin
				op.mode = MODE_TICK;
			end else if (r < 96) begin
				op.mode = MODE_SIGNAL;
				r = $urandom_range(0, 99);
				if (r < 60)
					op.n = SIG_BITS'($urandom_range(0, 1));
				else if (r < 78)
					op.n = SIG_BITS'($urandom_range(2, 6));
				else if (r < 99)
					op.n[SIG_BITS-1] = 1'b1;
			end else begin
				op.mode = MODE_UNUSED;
			end
			if (op.mode != MODE_UNUSED)
				done++;
			op_queue.push_back(op);
		end
	endtask

	task automatic settle();
		while (op_queue.size() != 0 || start || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_initial_count(logic [CFG_BITS-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data <= CFG_BITS'($urandom);
	endtask

	always @(negedge clk) begin
		if (arst_n && !(start && !taken)) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (op_queue.size() != 0 && !steady && $urandom_range(0, 99) < 15) begin
				start <= 1'b0;
				gap_left <= int'($urandom_range(0, 16));
			end else if (op_queue.size() != 0) begin
				next_op = op_queue.pop_front();
				start <= 1'b1;
				mode <= next_op.mode;
				thread_id <= next_op.tid;
				max_wait <= next_op.max_wait;
				signal_count <= next_op.n;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			taken <= start && !busy;
			if (strobe) begin
				seen = {kind, thread_out, value, last};
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: kind %0d thread %0d value %0d last %0b",
							kind, thread_out, value, last);
				end else begin
					want = due_results.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp kind %0d thread %0d value %0d last %0b,",
								" got kind %0d thread %0d value %0d last %0b"},
								want.kind, want.thread, $signed(want.value), want.last,
								kind, thread_out, value, last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				count_now = int'(cfg_data);
				line_len = 0;
			end
			if (start && !busy)
				semaphore_step({mode, thread_id, max_wait, signal_count});
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// fill the queue past full, then time out, release and saturate
		for (int i = 0; i < QUEUE_DEPTH; i++)
			add_op(MODE_WAIT, (i == 1) ? 8'hFF : THREAD_ID_BITS'(i * 37),
				(i == 1) ? 16'hFFFF : WAIT_BITS'(i % 3), '0);
		add_op(MODE_WAIT, 8'hA5, 16'h0001, '0);
		add_op(MODE_TICK, THREAD_ID_BITS'($urandom), WAIT_BITS'($urandom),
			SIG_BITS'($urandom));
		add_op(MODE_SIGNAL, THREAD_ID_BITS'($urandom), WAIT_BITS'($urandom), 16'sd0);
		add_op(MODE_SIGNAL, THREAD_ID_BITS'($urandom), WAIT_BITS'($urandom), 16'sd2);
		add_op(MODE_SIGNAL, THREAD_ID_BITS'($urandom), WAIT_BITS'($urandom), 16'h8000);
		add_op(MODE_SIGNAL, THREAD_ID_BITS'($urandom), WAIT_BITS'($urandom), 16'h7FFF);
		add_op(MODE_SIGNAL, THREAD_ID_BITS'($urandom), WAIT_BITS'($urandom), 16'h7FFF);
		add_op(MODE_WAIT, 8'h3C, 16'h0000, '0);
		add_op(MODE_UNUSED, THREAD_ID_BITS'($urandom), WAIT_BITS'($urandom),
			SIG_BITS'($urandom));
		add_random_ops(100);
		settle();

		write_initial_count(15'h7FFF);
		add_random_ops(40);
		settle();

		write_initial_count(15'd1);
		add_random_ops(110);
		settle();

		write_initial_count(CFG_BITS'($urandom_range(0, 32767)));
		add_random_ops(40);
		settle();

		write_initial_count(15'd0);
		add_random_ops(60);
		settle();

		write_initial_count(15'd3);
		steady = 1'b1;
		add_random_ops(100);
		settle();

		if (mismatches == 0 && due_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
